### src/otcw_pkg.sv
package otcw_pkg;

	localparam int DisplayWidthDefault  = 128;
	localparam int DisplayHeightDefault = 64;

	typedef enum logic [1:0] {
		EV_START = 2'd0,
		EV_DATA  = 2'd1,
		EV_STOP  = 2'd2
	} bus_event_t;

	typedef enum logic [1:0] {
		JOB_GLYPH       = 2'd0,
		JOB_GLYPH_WRAP  = 2'd1,
		JOB_CURSOR      = 2'd2
	} job_kind_t;

	localparam logic [7:0] ModeCmd  = 8'h00;
	localparam logic [7:0] ModeData = 8'h40;
	localparam logic [7:0] PageCmd  = 8'hB0;

	localparam int QueueDepth = 4;

	// one classified request between front and back
	typedef struct packed {
		job_kind_t  kind;
		logic [6:0] glyph;    // character - 32
		logic [7:0] col;      // cursor column for the cursor command
		logic [2:0] pg;       // page for the cursor command
	} job_t;

	function automatic logic [7:0] font_col(input logic [6:0] g, input logic [2:0] i);
		logic [39:0] row;
		case (g)
			7'd0:  row = 40'h0000000000;
			7'd1:  row = 40'h00005F0000;
			7'd2:  row = 40'h0007000700;
			7'd3:  row = 40'h147F147F14;
			7'd4:  row = 40'h242A7F2A12;
			7'd5:  row = 40'h2313086462;
			7'd6:  row = 40'h3649552250;
			7'd7:  row = 40'h0004030000;
			7'd8:  row = 40'h001C224100;
			7'd9:  row = 40'h0041221C00;
			7'd10: row = 40'h14083E0814;
			7'd11: row = 40'h08083E0808;
			7'd12: row = 40'h0080600000;
			7'd13: row = 40'h0808080808;
			7'd14: row = 40'h0060600000;
			7'd15: row = 40'h2010080402;
			7'd16: row = 40'h3E5149453E;
			7'd17: row = 40'h44427F4040;
			7'd18: row = 40'h4261514946;
			7'd19: row = 40'h2241494936;
			7'd20: row = 40'h1814127F10;
			7'd21: row = 40'h2F49494931;
			7'd22: row = 40'h3E49494932;
			7'd23: row = 40'h0301710907;
			7'd24: row = 40'h3649494936;
			7'd25: row = 40'h264949493E;
			7'd26: row = 40'h0036360000;
			7'd27: row = 40'h0080680000;
			7'd28: row = 40'h0008142200;
			7'd29: row = 40'h1414141414;
			7'd30: row = 40'h0022140800;
			7'd31: row = 40'h0201510906;
			7'd32: row = 40'h3E415D555E;
			7'd33: row = 40'h7C1211127C;
			7'd34: row = 40'h7F49494936;
			7'd35: row = 40'h3E41414122;
			7'd36: row = 40'h7F4141221C;
			7'd37: row = 40'h7F49494941;
			7'd38: row = 40'h7F09090901;
			7'd39: row = 40'h3E4149493A;
			7'd40: row = 40'h7F0808087F;
			7'd41: row = 40'h41417F4141;
			7'd42: row = 40'h2040413F01;
			7'd43: row = 40'h7F08142241;
			7'd44: row = 40'h7F40404040;
			7'd45: row = 40'h7F020C027F;
			7'd46: row = 40'h7F0408107F;
			7'd47: row = 40'h3E4141413E;
			7'd48: row = 40'h7F09090906;
			7'd49: row = 40'h3E4141C1BE;
			7'd50: row = 40'h7F09192946;
			7'd51: row = 40'h2649494932;
			7'd52: row = 40'h01017F0101;
			7'd53: row = 40'h3F4040403F;
			7'd54: row = 40'h1F2040201F;
			7'd55: row = 40'h3F4038403F;
			7'd56: row = 40'h6314081463;
			7'd57: row = 40'h0708700807;
			7'd58: row = 40'h6151494543;
			7'd59: row = 40'h007F414100;
			7'd60: row = 40'h0204081020;
			7'd61: row = 40'h0041417F00;
			7'd62: row = 40'h0804020408;
			7'd63: row = 40'h4040404040;
			7'd64: row = 40'h0006090906;
			7'd65: row = 40'h2054545478;
			7'd66: row = 40'h7F44444438;
			7'd67: row = 40'h3844444428;
			7'd68: row = 40'h384444447F;
			7'd69: row = 40'h3854545418;
			7'd70: row = 40'h08FE090102;
			7'd71: row = 40'h18A4A4A478;
			7'd72: row = 40'h7F04040478;
			7'd73: row = 40'h00447D4000;
			7'd74: row = 40'h0080847D00;
			7'd75: row = 40'h417F102844;
			7'd76: row = 40'h00417F4000;
			7'd77: row = 40'h7C047C0478;
			7'd78: row = 40'h7C04040478;
			7'd79: row = 40'h3844444438;
			7'd80: row = 40'hFC24242418;
			7'd81: row = 40'h18242424FC;
			7'd82: row = 40'h7C08040408;
			7'd83: row = 40'h0854545420;
			7'd84: row = 40'h043F444020;
			7'd85: row = 40'h3C4040403C;
			7'd86: row = 40'h1C2040201C;
			7'd87: row = 40'h3C4030403C;
			7'd88: row = 40'h4428102844;
			7'd89: row = 40'h1CA0A0A07C;
			7'd90: row = 40'h4464544C44;
			7'd91: row = 40'h0808364141;
			7'd92: row = 40'h0000FF0000;
			7'd93: row = 40'h4141360808;
			7'd94: row = 40'h0804081008;
			default: row = 40'hFFFFFFFFFF;
		endcase
		case (i)
			3'd0:    font_col = row[39:32];
			3'd1:    font_col = row[31:24];
			3'd2:    font_col = row[23:16];
			3'd3:    font_col = row[15:8];
			default: font_col = row[7:0];
		endcase
	endfunction

endpackage

### src/otcw_front.sv
module otcw_front
	import otcw_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = DisplayWidthDefault,
	parameter int DISPLAY_HEIGHT = DisplayHeightDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       opcode,
	input  logic [7:0] character,
	input  logic [7:0] column,
	input  logic [7:0] page,
	output logic       job_valid,
	output job_t       job,
	input  logic       job_full
);

	localparam int         Pages   = DISPLAY_HEIGHT / 8;
	localparam logic [7:0] WrapLim = 8'(DISPLAY_WIDTH - 6);

	logic [7:0] cur_col_q;
	logic [2:0] cur_pg_q;
	logic [6:0] ch;
	logic [7:0] adv_col;
	logic [3:0] nxt_pg;
	logic [2:0] nxt_pg_c;
	logic [2:0] set_pg;
	logic       accept;

	assign full   = job_full;
	assign accept = push && !full;
	assign ch     = character[6:0];
	assign adv_col = cur_col_q + 8'd6;
	assign nxt_pg   = {1'b0, cur_pg_q} + 4'd1;
	assign nxt_pg_c = (nxt_pg >= 4'(Pages)) ? 3'd0 : nxt_pg[2:0];
	assign set_pg   = (page >= 8'(Pages)) ? 3'd0 : page[2:0];

	always_comb begin
		job_valid = 1'b0;
		job.kind  = JOB_GLYPH;
		job.glyph = ch - 7'd32;
		job.col   = 8'd0;
		job.pg    = nxt_pg_c;
		if (accept) begin
			if (opcode) begin
				job_valid = 1'b1;
				job.kind  = JOB_CURSOR;
				job.col   = column;
				job.pg    = set_pg;
			end else if (ch >= 7'd32) begin
				job_valid = 1'b1;
				job.kind  = (adv_col > WrapLim) ? JOB_GLYPH_WRAP : JOB_GLYPH;
			end else if (ch == 7'd10) begin
				job_valid = 1'b1;
				job.kind  = JOB_CURSOR;
			end else if (ch == 7'd13) begin
				job_valid = 1'b1;
				job.kind  = JOB_CURSOR;
				job.pg    = cur_pg_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 8'd0;
			cur_pg_q  <= 3'd0;
		end else if (job_valid) begin
			if (job.kind == JOB_GLYPH) begin
				cur_col_q <= adv_col;
			end else begin
				cur_col_q <= job.col;
				cur_pg_q  <= job.pg;
			end
		end
	end

endmodule

### src/otcw_queue.sv
module otcw_queue
	import otcw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_data,
	output logic full,
	input  logic rd,
	output logic empty,
	output job_t rd_data
);

	localparam int Aw = $clog2(QueueDepth);

	job_t          mem_q [QueueDepth];
	logic [Aw-1:0] wp_q;
	logic [Aw-1:0] rp_q;
	logic [Aw:0]   cnt_q;

	assign full    = cnt_q == (Aw+1)'(QueueDepth);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
		end
	end

endmodule

### src/otcw_back.sv
module otcw_back
	import otcw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] device_address,
	input  logic [6:0] column_offset,
	input  logic       job_empty,
	input  job_t       job,
	output logic       job_pop,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] bus_event,
	output logic [7:0] bus_byte,
	output logic       last_of_run
);

	// step 0..8 glyph run, 9..14 cursor run
	logic [3:0] step_q;
	logic [3:0] first_step;
	logic [3:0] last_step;
	logic       go;
	logic [1:0] ev;
	logic [7:0] byt;
	logic [7:0] addr;
	logic       fin;

	assign first_step = (job.kind == JOB_CURSOR) ? 4'd9 : 4'd0;
	assign last_step  = (job.kind == JOB_GLYPH) ? 4'd8 : 4'd14;
	assign go   = !job_empty && (empty || pop);
	assign fin  = step_q == last_step;
	assign job_pop = go && fin;
	assign addr = {1'b0, column_offset} + job.col;

	always_comb begin
		ev  = EV_DATA;
		byt = 8'd0;
		case (step_q)
			4'd0, 4'd9: begin
				ev  = EV_START;
				byt = {device_address, 1'b0};
			end
			4'd1:  byt = ModeData;
			4'd2:  byt = 8'd0;
			4'd3, 4'd4, 4'd5, 4'd6, 4'd7:
				byt = font_col(job.glyph, 3'(step_q - 4'd3));
			4'd8, 4'd14: ev = EV_STOP;
			4'd10: byt = ModeCmd;
			4'd11: byt = PageCmd + {5'd0, job.pg};
			4'd12: byt = {4'd0, addr[3:0]};
			4'd13: byt = {4'h1, addr[7:4]};
			default: ev = EV_STOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty  <= 1'b1;
			step_q <= 4'd0;
		end else begin
			if (go) begin
				empty <= 1'b0;
				if (fin) begin
					step_q <= 4'd0;
				end else if (step_q == 4'd0 && first_step == 4'd9) begin
					// cursor job: step 0 stands in for the start at step 9
					step_q <= 4'd10;
				end else if (step_q == 4'd8) begin
					step_q <= 4'd9;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end else if (pop) begin
				empty <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			bus_event   <= (go && step_q == 4'd0 && first_step == 4'd9) ? EV_START : ev;
			bus_byte    <= byt;
			last_of_run <= fin;
		end
	end

endmodule

### src/oled_text_character_writer.sv
// Text writer for a page-addressed OLED controller.
// Input queue side: push with opcode/character/column/page; full holds it off.
// Result queue side: while empty is low, bus_event/bus_byte/last_of_run show
// the oldest bus request; pop takes it.
// A printable character gives 9 bus requests (15 when the line wraps), a
// cursor move, LF or CR gives 6, other control characters none.
// The back end emits one bus request per cycle while pop keeps pace; an
// item's first request passes through the job queue and the output register.
// A four-entry job queue sits between the front (cursor tracking) and the
// back (byte sequencing), so input keeps flowing while results stall.
// Stalling pop freezes the back end; once the job queue fills, full rises.
// Reset clears the cursor to column 0, page 0, sets device address 60 and
// column offset 0, and empties both queues.
// Configuration: cfg_index 0 device address, 1 column offset; cfg_ready is
// always high and writes belong only to idle periods.
module oled_text_character_writer
	import otcw_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = DisplayWidthDefault,
	parameter int DISPLAY_HEIGHT = DisplayHeightDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       opcode,
	input  logic [7:0] character,
	input  logic [7:0] column,
	input  logic [7:0] page,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] bus_event,
	output logic [7:0] bus_byte,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	logic [6:0] dev_addr_q;
	logic [6:0] col_off_q;
	logic       job_valid;
	job_t       job_in;
	logic       job_full;
	logic       job_empty;
	job_t       job_out;
	logic       job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 7'd60;
			col_off_q  <= 7'd0;
		end else if (cfg_valid) begin
			if (cfg_index) begin
				col_off_q <= cfg_data;
			end else begin
				dev_addr_q <= cfg_data;
			end
		end
	end

	otcw_front #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.character(character),
		.column   (column),
		.page     (page),
		.job_valid(job_valid),
		.job      (job_in),
		.job_full (job_full)
	);

	otcw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_valid),
		.wr_data(job_in),
		.full   (job_full),
		.rd     (job_pop),
		.empty  (job_empty),
		.rd_data(job_out)
	);

	otcw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.device_address(dev_addr_q),
		.column_offset (col_off_q),
		.job_empty     (job_empty),
		.job           (job_out),
		.job_pop       (job_pop),
		.empty         (empty),
		.pop           (pop),
		.bus_event     (bus_event),
		.bus_byte      (bus_byte),
		.last_of_run   (last_of_run)
	);

endmodule
